/* hw/rtl/fault_escalation_monitor_core_defines.svh */
// ---------------------------------------------------------------------------
// Fault escalation monitor: assertion macros
// Shared property wrappers for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef FAULT_ESCALATION_MONITOR_CORE_DEFINES_SVH
`define FAULT_ESCALATION_MONITOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FEM_ASSERT_IMPLIES(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error("%m: property failed");

// Condition that must hold on the cycle after reset is seen.
`define FEM_ASSERT_AFTER_RESET(label, cons) \
  label: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("%m: bad state after reset");

`endif

/* hw/rtl/fem_pkg.sv */
// ---------------------------------------------------------------------------
// Fault escalation monitor package
// Widths, level codes, register indexes and shared structs.
// ---------------------------------------------------------------------------
`default_nettype none

package fem_pkg;

  localparam int SAMPLE_W    = 32;
  localparam int LIMIT_W     = 31;
  localparam int TICK_W      = 16;
  localparam int RUN_W       = 8;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  typedef logic [1:0]         level_t;
  typedef logic [LIMIT_W-1:0] limit_t;
  typedef logic [TICK_W-1:0]  tick_t;
  typedef logic [RUN_W-1:0]   run_t;

  localparam level_t LVL_NOMINAL   = 2'd0;
  localparam level_t LVL_COMPLIANT = 2'd1;
  localparam level_t LVL_REDUCE    = 2'd2;
  localparam level_t LVL_STOP      = 2'd3;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam run_t COMPLIANT_RUN_NEEDED = 8'd3;
  localparam run_t REDUCE_RUN_NEEDED    = 8'd3;
  localparam run_t STOP_RUN_NEEDED      = 8'd2;
  localparam run_t RUN_MAX              = '1;
  localparam tick_t TICK_MAX            = '1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TORQUE_COMPLIANT = 3'd0,
    REG_TORQUE_REDUCE    = 3'd1,
    REG_TORQUE_STOP      = 3'd2,
    REG_SPEED_COMPLIANT  = 3'd3,
    REG_SPEED_REDUCE     = 3'd4,
    REG_SPEED_STOP       = 3'd5,
    REG_SILENCE_TIMEOUT  = 3'd6,
    REG_STARTUP_GRACE    = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    limit_t torque_compliant;
    limit_t torque_reduce;
    limit_t torque_stop;
    limit_t speed_compliant;
    limit_t speed_reduce;
    limit_t speed_stop;
    tick_t  silence_timeout;
    tick_t  startup_grace;
  } cfg_t;

  typedef struct packed {
    logic   request_valid;
    level_t request_level;
    level_t latched_level;
    logic   watchdog_fired;
    logic   monitoring_active;
    level_t instant_level;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/fem_config.sv */
// ---------------------------------------------------------------------------
// Fault escalation monitor: configuration registers
// Limit and tick registers written through the configuration channel.
// ---------------------------------------------------------------------------
`default_nettype none

module fem_config (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [fem_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [fem_pkg::CFG_DATA_W-1:0]  wr_data,
  output fem_pkg::cfg_t                  cfg
);
  import fem_pkg::*;

  cfg_t cfg_regs;
  cfg_reg_t wr_reg;

  assign wr_reg = cfg_reg_t'(wr_index);
  assign cfg    = cfg_regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.torque_compliant <= LIMIT_W'(131072);
      cfg_regs.torque_reduce    <= LIMIT_W'(196608);
      cfg_regs.torque_stop      <= LIMIT_W'(262144);
      cfg_regs.speed_compliant  <= LIMIT_W'(65536);
      cfg_regs.speed_reduce     <= LIMIT_W'(131072);
      cfg_regs.speed_stop       <= LIMIT_W'(196608);
      cfg_regs.silence_timeout  <= TICK_W'(5);
      cfg_regs.startup_grace    <= TICK_W'(20);
    end else if (wr_en) begin
      unique case (wr_reg)
        REG_TORQUE_COMPLIANT: cfg_regs.torque_compliant <= wr_data[LIMIT_W-1:0];
        REG_TORQUE_REDUCE:    cfg_regs.torque_reduce    <= wr_data[LIMIT_W-1:0];
        REG_TORQUE_STOP:      cfg_regs.torque_stop      <= wr_data[LIMIT_W-1:0];
        REG_SPEED_COMPLIANT:  cfg_regs.speed_compliant  <= wr_data[LIMIT_W-1:0];
        REG_SPEED_REDUCE:     cfg_regs.speed_reduce     <= wr_data[LIMIT_W-1:0];
        REG_SPEED_STOP:       cfg_regs.speed_stop       <= wr_data[LIMIT_W-1:0];
        REG_SILENCE_TIMEOUT:  cfg_regs.silence_timeout  <= wr_data[TICK_W-1:0];
        REG_STARTUP_GRACE:    cfg_regs.startup_grace    <= wr_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fem_grader.sv */
// ---------------------------------------------------------------------------
// Fault escalation monitor: sample grader
// Grades torque and velocity magnitudes and returns the worse level.
// ---------------------------------------------------------------------------
`default_nettype none

module fem_grader (
  input  logic signed [fem_pkg::SAMPLE_W-1:0] torque,
  input  logic signed [fem_pkg::SAMPLE_W-1:0] speed,
  input  fem_pkg::cfg_t                       cfg,
  output fem_pkg::level_t                     level
);
  import fem_pkg::*;

  logic [SAMPLE_W-1:0] torque_mag;
  logic [SAMPLE_W-1:0] speed_mag;
  level_t torque_level;
  level_t speed_level;

  // Most negative value negates to itself, which is 2^31 read unsigned.
  function automatic logic [SAMPLE_W-1:0] magnitude(logic [SAMPLE_W-1:0] raw);
    return raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
  endfunction

  // Highest limit reached wins.
  function automatic level_t grade(logic [SAMPLE_W-1:0] mag, limit_t l1, limit_t l2,
                                   limit_t l3);
    level_t lvl;
    if (mag >= {1'b0, l3})      lvl = LVL_STOP;
    else if (mag >= {1'b0, l2}) lvl = LVL_REDUCE;
    else if (mag >= {1'b0, l1}) lvl = LVL_COMPLIANT;
    else                        lvl = LVL_NOMINAL;
    return lvl;
  endfunction

  always_comb begin
    torque_mag   = magnitude(torque);
    speed_mag    = magnitude(speed);
    torque_level = grade(torque_mag, cfg.torque_compliant, cfg.torque_reduce,
                         cfg.torque_stop);
    speed_level  = grade(speed_mag, cfg.speed_compliant, cfg.speed_reduce,
                         cfg.speed_stop);
    level        = (torque_level >= speed_level) ? torque_level : speed_level;
  end

endmodule

`default_nettype wire

/* hw/rtl/fem_tracker.sv */
// ---------------------------------------------------------------------------
// Fault escalation monitor: escalation tracker
// Run counters, upward-only latch, grace period and silence watchdog.
// ---------------------------------------------------------------------------
`default_nettype none

module fem_tracker (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              operation,
  input  fem_pkg::level_t   instant_level,
  input  fem_pkg::cfg_t     cfg,
  output fem_pkg::result_t  result
);
  import fem_pkg::*;

  level_t requested_latch, requested_latch_next;
  run_t   compliant_run, compliant_run_next;
  run_t   reduce_run, reduce_run_next;
  run_t   stop_run, stop_run_next;
  logic   grace_active, grace_active_next;
  tick_t  grace_elapsed, grace_elapsed_next;
  logic   seen_sample, seen_sample_next;
  logic   watchdog_latched, watchdog_latched_next;
  tick_t  silence_elapsed, silence_elapsed_next;

  tick_t  silence_inc;
  logic   graded;
  run_t   compliant_base, reduce_base, stop_base;
  level_t latch_base;
  level_t debounced;

  function automatic run_t run_update(run_t run, logic hit);
    run_t r;
    if (!hit)               r = '0;
    else if (run != RUN_MAX) r = run + 1'b1;
    else                    r = run;
    return r;
  endfunction

  always_comb begin
    requested_latch_next  = requested_latch;
    compliant_run_next    = compliant_run;
    reduce_run_next       = reduce_run;
    stop_run_next         = stop_run;
    grace_active_next     = grace_active;
    grace_elapsed_next    = grace_elapsed;
    seen_sample_next      = seen_sample;
    watchdog_latched_next = watchdog_latched;
    silence_elapsed_next  = silence_elapsed;
    silence_inc           = (silence_elapsed != TICK_MAX) ? silence_elapsed + 1'b1
                                                          : silence_elapsed;
    graded                = 1'b0;
    compliant_base        = compliant_run;
    reduce_base           = reduce_run;
    stop_base             = stop_run;
    latch_base            = requested_latch;
    debounced             = LVL_NOMINAL;
    result                = '0;

    if (operation == OP_TICK) begin
      if (grace_active) begin
        if (grace_elapsed != TICK_MAX) grace_elapsed_next = grace_elapsed + 1'b1;
      end else if (seen_sample) begin
        silence_elapsed_next = silence_inc;
        if (silence_inc >= cfg.silence_timeout && !watchdog_latched) begin
          watchdog_latched_next = 1'b1;
          result.watchdog_fired = 1'b1;
          if (requested_latch != LVL_STOP) begin
            requested_latch_next = LVL_STOP;
            result.request_valid = 1'b1;
            result.request_level = LVL_STOP;
          end
        end
      end
    end else begin
      graded = !(grace_active && (grace_elapsed < cfg.startup_grace));
      if (graded) begin
        // First graded sample after grace starts from a clean slate.
        if (grace_active) begin
          compliant_base = '0;
          reduce_base    = '0;
          stop_base      = '0;
          latch_base     = LVL_NOMINAL;
        end
        grace_active_next     = 1'b0;
        seen_sample_next      = 1'b1;
        watchdog_latched_next = 1'b0;
        silence_elapsed_next  = '0;
        compliant_run_next    = run_update(compliant_base, instant_level >= LVL_COMPLIANT);
        reduce_run_next       = run_update(reduce_base, instant_level >= LVL_REDUCE);
        stop_run_next         = run_update(stop_base, instant_level == LVL_STOP);
        if (stop_run_next >= STOP_RUN_NEEDED)                debounced = LVL_STOP;
        else if (reduce_run_next >= REDUCE_RUN_NEEDED)       debounced = LVL_REDUCE;
        else if (compliant_run_next >= COMPLIANT_RUN_NEEDED) debounced = LVL_COMPLIANT;
        else                                                 debounced = LVL_NOMINAL;
        requested_latch_next = latch_base;
        if (debounced > latch_base) begin
          requested_latch_next = debounced;
          result.request_valid = 1'b1;
          result.request_level = debounced;
        end
        result.instant_level = instant_level;
      end
    end

    result.latched_level     = requested_latch_next;
    result.monitoring_active = !grace_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_latch  <= LVL_NOMINAL;
      compliant_run    <= '0;
      reduce_run       <= '0;
      stop_run         <= '0;
      grace_active     <= 1'b1;
      grace_elapsed    <= '0;
      seen_sample      <= 1'b0;
      watchdog_latched <= 1'b0;
      silence_elapsed  <= '0;
    end else if (step) begin
      requested_latch  <= requested_latch_next;
      compliant_run    <= compliant_run_next;
      reduce_run       <= reduce_run_next;
      stop_run         <= stop_run_next;
      grace_active     <= grace_active_next;
      grace_elapsed    <= grace_elapsed_next;
      seen_sample      <= seen_sample_next;
      watchdog_latched <= watchdog_latched_next;
      silence_elapsed  <= silence_elapsed_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/fault_escalation_monitor_core.sv */
// ---------------------------------------------------------------------------
// Fault escalation monitor core
// Escalation monitor for torque and joint velocity samples with watchdog.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item per transfer: a status
//   sample (operation 0, signed Q16.16 torque and velocity) or a 100 ms time
//   tick (operation 1). Every item yields exactly one result transfer on the
//   output channel (out_valid/out_ready).
//   Each item waits in the input register, then moves to the result register,
//   which raises out_valid. Throughput: one item per cycle unless the
//   receiver stalls; grading, run counters and latch update sit in one
//   combinational step between the two registers.
//   When the receiver stalls, the result register holds and the input
//   register takes one more item; in_ready then drops until out_ready returns.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data, always
//   ready; write only while no item is in flight.
//   Reset (rst, synchronous) empties both registers, restores all limits to
//   their defaults, restarts the grace period and clears the latch.
// ---------------------------------------------------------------------------
`default_nettype none

module fault_escalation_monitor_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            operation,
  input  logic signed [fem_pkg::SAMPLE_W-1:0] torque_sample,
  input  logic signed [fem_pkg::SAMPLE_W-1:0] speed_sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            request_valid,
  output fem_pkg::level_t                 request_level,
  output fem_pkg::level_t                 latched_level,
  output logic                            watchdog_fired,
  output logic                            monitoring_active,
  output fem_pkg::level_t                 instant_level,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fem_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fem_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fem_pkg::*;

  logic                       in_full;
  logic                       op_q;
  logic signed [SAMPLE_W-1:0] torque_q;
  logic signed [SAMPLE_W-1:0] speed_q;
  logic                       advance;
  cfg_t                       cfg;
  level_t                     graded_level;
  result_t                    result;
  result_t                    result_q;

  assign cfg_ready = 1'b1;
  assign advance   = in_full && (!out_valid || out_ready);
  assign in_ready  = !in_full || advance;

  fem_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  fem_grader u_grader (
    .torque (torque_q),
    .speed  (speed_q),
    .cfg    (cfg),
    .level  (graded_level)
  );

  fem_tracker u_tracker (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .operation     (op_q),
    .instant_level (graded_level),
    .cfg           (cfg),
    .result        (result)
  );

  // Input register: load on transfer, drain when the result stage moves.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q     <= operation;
      torque_q <= torque_sample;
      speed_q  <= speed_sample;
    end
  end

  // Result register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign request_valid     = result_q.request_valid;
  assign request_level     = result_q.request_level;
  assign latched_level     = result_q.latched_level;
  assign watchdog_fired    = result_q.watchdog_fired;
  assign monitoring_active = result_q.monitoring_active;
  assign instant_level     = result_q.instant_level;

endmodule

`default_nettype wire

/* hw/rtl/fem_checker.sv */
// ---------------------------------------------------------------------------
// Fault escalation monitor: port checker
// Consistency checks on the result channel, bound to the core.
// ---------------------------------------------------------------------------
`default_nettype none

`include "fault_escalation_monitor_core_defines.svh"

module fem_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_ready,
  input  logic            out_valid,
  input  logic            request_valid,
  input  fem_pkg::level_t request_level,
  input  fem_pkg::level_t latched_level,
  input  logic            watchdog_fired,
  input  logic            monitoring_active,
  input  fem_pkg::level_t instant_level
);
  import fem_pkg::*;

  // A request always lands in the latch at the level it reports.
  `FEM_ASSERT_IMPLIES(a_request_latched, out_valid && request_valid,
    request_level != LVL_NOMINAL && latched_level == request_level)

  // No request, no level.
  `FEM_ASSERT_IMPLIES(a_idle_level_zero, out_valid && !request_valid,
    request_level == LVL_NOMINAL)

  // Watchdog always leaves the latch at safe stop.
  `FEM_ASSERT_IMPLIES(a_watchdog_stop, out_valid && watchdog_fired,
    latched_level == LVL_STOP)

  // During grace nothing is graded or raised.
  `FEM_ASSERT_IMPLIES(a_grace_quiet, out_valid && !monitoring_active,
    !request_valid && !watchdog_fired && instant_level == LVL_NOMINAL)

  `FEM_ASSERT_AFTER_RESET(a_reset_empty, !out_valid && in_ready)

endmodule

bind fault_escalation_monitor_core fem_checker u_fem_checker (
  .clk               (clk),
  .rst               (rst),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .request_valid     (request_valid),
  .request_level     (request_level),
  .latched_level     (latched_level),
  .watchdog_fired    (watchdog_fired),
  .monitoring_active (monitoring_active),
  .instant_level     (instant_level)
);

`default_nettype wire
